// ===== rtl/sample_histogram_quantile_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sample histogram quantile engine
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_HISTOGRAM_QUANTILE_ENGINE_DEFINES_SVH
`define SAMPLE_HISTOGRAM_QUANTILE_ENGINE_DEFINES_SVH

// property must hold at every clock edge out of reset
`define SHQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define SHQE_ASSERT_NEVER(lbl, expr, msg) \
  `SHQE_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/shqe_pkg.sv =====
// ----------------------------------------------------------------------------
// shqe_pkg
// Types and fixed constants shared by the histogram quantile engine modules.
// ----------------------------------------------------------------------------
package shqe_pkg;

  localparam int unsigned SID_W      = 4;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned BIN_OUT_W  = 10;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned POS_CNT_W  = 5;
  localparam int unsigned POS_SEL_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned PCT_SCALE = 100;

  localparam logic [POS_CNT_W-1:0]  POS_COUNT_RST = 5'd10;
  localparam logic [CFG_DATA_W-1:0] POS_LOW_RST   = 64'h5046_3C32_281E_140A;
  localparam logic [CFG_DATA_W-1:0] POS_HIGH_RST  = 64'h0000_0000_0000_645A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_COUNT = 2'd0,
    REG_POS_LOW   = 2'd1,
    REG_POS_HIGH  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_ADD    = 1'b0,
    MODE_REPORT = 1'b1
  } mode_e;

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SUM_RD,
    ST_SUM_END,
    ST_SETUP,
    ST_WALK_RD,
    ST_WALK_MUL,
    ST_WALK_ACC,
    ST_WALK_TEST,
    ST_WALK_THR,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic                mode;
    logic [SID_W-1:0]    stream_id;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [SID_W-1:0]     stream_id_out;
    logic [PCT_W-1:0]     percentile;
    logic [BIN_OUT_W-1:0] bin_value;
    logic                 last;
  } out_item_t;

  // position under test and what follows from it
  typedef struct packed {
    logic [POS_CNT_W-1:0] npos;
    logic [POS_W-1:0]     pos_cur;
    logic                 last_pos;
  } pos_info_t;

endpackage

// ===== rtl/shqe_cfg.sv =====
// ----------------------------------------------------------------------------
// shqe_cfg
// Position registers, write decode and selection of the position under test.
// ----------------------------------------------------------------------------
module shqe_cfg #(
  parameter int unsigned MAX_POSITIONS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [shqe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [shqe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [shqe_pkg::POS_CNT_W-1:0]      k_i,
  output shqe_pkg::pos_info_t                 pos_o
);
  import shqe_pkg::*;

  localparam logic [POS_CNT_W-1:0] NPOS_MAX = POS_CNT_W'(MAX_POSITIONS);

  logic [POS_CNT_W-1:0]    pos_count_q, pos_count_d;
  logic [CFG_DATA_W-1:0]   pos_low_q, pos_low_d;
  logic [CFG_DATA_W-1:0]   pos_high_q, pos_high_d;
  logic [2*CFG_DATA_W-1:0] pos_all;
  logic [POS_CNT_W-1:0]    k_next;
  logic [POS_W-1:0]        pos_next;

  always_comb begin
    pos_count_d = pos_count_q;
    pos_low_d   = pos_low_q;
    pos_high_d  = pos_high_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_POS_COUNT: pos_count_d = cfg_data_i[POS_CNT_W-1:0];
        REG_POS_LOW:   pos_low_d   = cfg_data_i;
        REG_POS_HIGH:  pos_high_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_count_q <= POS_COUNT_RST;
      pos_low_q   <= POS_LOW_RST;
      pos_high_q  <= POS_HIGH_RST;
    end else begin
      pos_count_q <= pos_count_d;
      pos_low_q   <= pos_low_d;
      pos_high_q  <= pos_high_d;
    end
  end

  assign pos_all = {pos_high_q, pos_low_q};
  assign k_next  = k_i + POS_CNT_W'(1);
  assign pos_next = pos_all[{k_next[POS_SEL_W-1:0], 3'b000} +: POS_W];

  always_comb begin
    pos_o.npos    = (pos_count_q > NPOS_MAX) ? NPOS_MAX : pos_count_q;
    pos_o.pos_cur = pos_all[{k_i[POS_SEL_W-1:0], 3'b000} +: POS_W];
    // a position above 100 is never reached, so nothing after it is emitted
    pos_o.last_pos = (k_next == pos_o.npos) || (pos_next > POS_W'(PCT_SCALE));
  end

endmodule

// ===== rtl/sample_histogram_quantile_engine.sv =====
// ----------------------------------------------------------------------------
// sample_histogram_quantile_engine
// One histogram per stream in a single-port count memory. An add item bumps
// the clamped bin (saturating) through accept, read and write back. A report
// item totals the histogram bin by bin, sets up the first threshold, walks
// the bins (read, multiply, accumulate, test; a threshold update per result,
// held while the output is stalled), then clears the histogram; an empty
// histogram ends after the totaling pass. Every phase goes through the one
// memory port; totaling and walk use separate accumulators. After reset the
// whole memory (NUM_STREAMS * NUM_BINS entries) is zeroed one entry a cycle,
// and no item is taken until that pass ends; configuration writes are taken anytime.
// ----------------------------------------------------------------------------
module sample_histogram_quantile_engine #(
  parameter int unsigned NUM_BINS      = 1024,
  parameter int unsigned NUM_STREAMS   = 16,
  parameter int unsigned MAX_POSITIONS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  shqe_pkg::in_item_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output shqe_pkg::out_item_t              out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [shqe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [shqe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import shqe_pkg::*;

  `include "sample_histogram_quantile_engine_defines.svh"

  localparam int unsigned BW    = $clog2(NUM_BINS);
  localparam int unsigned DEPTH = NUM_STREAMS * NUM_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SUMW  = CNT_W + BW;
  localparam int unsigned PRODW = CNT_W + 7;
  localparam int unsigned CUMW  = SUMW + 7;
  localparam int unsigned THRW  = SUMW + POS_W;

  localparam logic [BW-1:0] BIN_LAST = BW'(NUM_BINS - 1);
  localparam logic [AW-1:0] MEM_LAST = AW'(DEPTH - 1);

  state_e state_q, state_d;

  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic [SID_W-1:0]   sid_q, sid_d;
  logic [BW-1:0]      bin_q, bin_d;
  logic [SUMW-1:0]    total_q, total_d;
  logic [PRODW-1:0]   prod_q, prod_d;
  logic [CUMW-1:0]    cum100_q, cum100_d;
  logic [THRW-1:0]    thr_q, thr_d;
  logic [POS_CNT_W-1:0] k_q, k_d;
  logic               rd_vld_q;
  logic [CNT_W-1:0]   rd_data_q;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic [CNT_W-1:0]   hist_mem [DEPTH];
  logic [AW-1:0]      mem_addr;
  logic               mem_we, mem_re;
  logic [CNT_W-1:0]   mem_wdata;

  pos_info_t          pos_info;
  logic               accept, sid_ok, pos_done, pct_ge, out_free, emit;
  logic [BW-1:0]      bin_clamped;

  shqe_cfg #(
    .MAX_POSITIONS(MAX_POSITIONS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .k_i         (k_q),
    .pos_o       (pos_info)
  );

  assign cfg_ready_o = 1'b1;

  assign accept      = in_valid_i && !in_stall_o;
  assign sid_ok      = 32'(in_data_i.stream_id) < 32'(NUM_STREAMS);
  assign bin_clamped = (32'(in_data_i.sample) > 32'(NUM_BINS - 1)) ? BIN_LAST
                                                                   : BW'(in_data_i.sample);
  assign pos_done    = k_q >= pos_info.npos;
  // floor(cum*100/total) >= p  <=>  cum*100 >= p*total
  assign pct_ge      = THRW'(cum100_q) >= thr_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT_CLR: if (clr_addr_q == MEM_LAST) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept && sid_ok) begin
          state_d = (in_data_i.mode == MODE_REPORT) ? ST_SUM_RD : ST_ADD_RD;
        end
      end
      ST_ADD_RD:  state_d = ST_ADD_WR;
      ST_ADD_WR:  state_d = ST_IDLE;
      ST_SUM_RD:  if (bin_q == BIN_LAST) state_d = ST_SUM_END;
      ST_SUM_END: state_d = ST_SETUP;
      ST_SETUP: begin
        priority if (total_q == '0) state_d = ST_IDLE;
        else if (pos_info.npos == '0) state_d = ST_CLEAR;
        else state_d = ST_WALK_RD;
      end
      ST_WALK_RD:  state_d = ST_WALK_MUL;
      ST_WALK_MUL: state_d = ST_WALK_ACC;
      ST_WALK_ACC: state_d = ST_WALK_TEST;
      ST_WALK_TEST: begin
        priority if (pos_done) state_d = ST_CLEAR;
        else if (pct_ge) state_d = out_free ? ST_WALK_THR : ST_WALK_TEST;
        else if (bin_q == BIN_LAST) state_d = ST_CLEAR;
        else state_d = ST_WALK_RD;
      end
      ST_WALK_THR: state_d = ST_WALK_TEST;
      ST_CLEAR:    if (bin_q == BIN_LAST) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mem_re     = (state_q == ST_ADD_RD) || (state_q == ST_SUM_RD) || (state_q == ST_WALK_RD);
    mem_we     = (state_q == ST_INIT_CLR) || (state_q == ST_ADD_WR) || (state_q == ST_CLEAR);
    mem_wdata  = '0;
    if (state_q == ST_ADD_WR) begin
      mem_wdata = (rd_data_q == '1) ? rd_data_q : rd_data_q + CNT_W'(1);
    end
    mem_addr = (state_q == ST_INIT_CLR) ? clr_addr_q
                                        : AW'(32'(sid_q) * 32'(NUM_BINS) + 32'(bin_q));
    emit = (state_q == ST_WALK_TEST) && !pos_done && pct_ge && out_free;
  end

  // datapath
  always_comb begin
    clr_addr_d = clr_addr_q;
    sid_d      = sid_q;
    bin_d      = bin_q;
    total_d    = total_q;
    prod_d     = prod_q;
    cum100_d   = cum100_q;
    thr_d      = thr_q;
    k_d        = k_q;

    if (rd_vld_q) total_d = total_q + SUMW'(rd_data_q);

    unique case (state_q)
      ST_INIT_CLR: clr_addr_d = clr_addr_q + AW'(1);
      ST_IDLE: begin
        if (accept) begin
          sid_d    = in_data_i.stream_id;
          bin_d    = (in_data_i.mode == MODE_REPORT) ? '0 : bin_clamped;
          total_d  = '0;
          cum100_d = '0;
          k_d      = '0;
        end
      end
      ST_SUM_RD: bin_d = bin_q + BW'(1);
      ST_SETUP: begin
        bin_d = '0;
        thr_d = THRW'(pos_info.pos_cur) * THRW'(total_q);
      end
      ST_WALK_MUL: prod_d = PRODW'(rd_data_q) * PRODW'(PCT_SCALE);
      ST_WALK_ACC: cum100_d = cum100_q + CUMW'(prod_q);
      ST_WALK_TEST: begin
        priority if (pos_done) bin_d = '0;
        else if (pct_ge) begin
          if (out_free) k_d = k_q + POS_CNT_W'(1);
        end else if (bin_q == BIN_LAST) bin_d = '0;
        else bin_d = bin_q + BW'(1);
      end
      ST_WALK_THR: thr_d = THRW'(pos_info.pos_cur) * THRW'(total_q);
      ST_CLEAR:    bin_d = bin_q + BW'(1);
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d         = 1'b1;
      out_d.stream_id_out = sid_q;
      out_d.percentile    = PCT_W'(pos_info.pos_cur);
      out_d.bin_value     = BIN_OUT_W'(bin_q);
      out_d.last          = pos_info.last_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT_CLR;
      clr_addr_q  <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      rd_vld_q    <= (state_q == ST_SUM_RD);
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sid_q    <= sid_d;
    bin_q    <= bin_d;
    total_q  <= total_d;
    prod_q   <= prod_d;
    cum100_q <= cum100_d;
    thr_q    <= thr_d;
    out_q    <= out_d;
  end

  // count store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) hist_mem[mem_addr] <= mem_wdata;
    if (mem_re) rd_data_q <= hist_mem[mem_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SHQE_ASSERT(a_pct_range, out_valid_o |-> (out_data_o.percentile <= PCT_W'(PCT_SCALE)), "percentile above 100")
  `SHQE_ASSERT(a_k_bound, (state_q == ST_WALK_TEST) |-> (k_q <= pos_info.npos), "position index past count")
  `SHQE_ASSERT(a_walk_total, (state_q == ST_WALK_RD || state_q == ST_WALK_TEST) |-> (total_q != '0), "walk on empty histogram")
  `SHQE_ASSERT(a_add_writes, (accept && sid_ok && in_data_i.mode == MODE_ADD) |-> ##2 mem_we, "add did not write back")
  `SHQE_ASSERT_NEVER(a_port_clash, mem_we && mem_re, "read and write in one cycle")

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for sample_histogram_quantile_engine
// The stimulus opens with a table of directed items and register writes:
// empty reports, bin clamping, and saturated, zero, unreachable and
// unordered position lists. Random add bursts, each closed by a report,
// follow under three idle profiles. Every result transfer is checked field by
// field against the table's expected results or a local histogram predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shqe_pkg::*;

  localparam int NUM_BINS    = 1024;
  localparam int NUM_STREAMS = 16;
  localparam int MAX_POS     = 16;
  // worst tail after the last result: full walk of all bins, then the clear pass
  localparam int DRAIN_CYCLES = 6 * NUM_BINS + 2000;

  typedef struct {
    bit          is_cfg;
    cfg_reg_e    idx;
    logic [63:0] data;
    in_item_t    item;
    int          exp_n;    // -1: use the predictor
    logic [9:0]  exp_bin;
  } step_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // predictor state
  bit [CNT_W-1:0] hist_bank [NUM_STREAMS][NUM_BINS];
  logic [4:0]     pos_count_q;
  logic [63:0]    pos_lo_q;
  logic [63:0]    pos_hi_q;

  out_item_t new_pcts[$];
  out_item_t due_pcts[$];
  step_t     steps[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int fails;

  sample_histogram_quantile_engine #(
    .NUM_BINS      (NUM_BINS),
    .NUM_STREAMS   (NUM_STREAMS),
    .MAX_POSITIONS (MAX_POS)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #40ms;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
  end

  function automatic void note_mismatch(string what, out_item_t want, out_item_t got);
    fails++;
    if (fails <= 10) begin
      $display("%t %s: exp sid=%0d pct=%0d bin=%0d last=%0b got sid=%0d pct=%0d bin=%0d last=%0b",
               $realtime, what, want.stream_id_out, want.percentile, want.bin_value,
               want.last, got.stream_id_out, got.percentile, got.bin_value, got.last);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_pcts.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data_o);
      end else begin
        if (out_data_o.stream_id_out !== due_pcts[0].stream_id_out ||
            out_data_o.percentile    !== due_pcts[0].percentile ||
            out_data_o.bin_value     !== due_pcts[0].bin_value ||
            out_data_o.last          !== due_pcts[0].last) begin
          note_mismatch("result mismatch", due_pcts[0], out_data_o);
        end
        void'(due_pcts.pop_front());
      end
    end
  end

  function automatic logic [7:0] pos_at(int k);
    if (k < 8) return pos_lo_q[8*k +: 8];
    return pos_hi_q[8*(k-8) +: 8];
  endfunction

  // add bumps a clamped bin; report walks the cumulative counts, then clears
  task automatic apply_item(input in_item_t it);
    int          bin;
    int          npos;
    int          k;
    logic [63:0] total;
    logic [63:0] cum;
    logic [63:0] pct;
    logic [7:0]  pv;
    out_item_t   r;
    new_pcts.delete();
    if (it.mode == MODE_ADD) begin
      bin = (it.sample > NUM_BINS - 1) ? NUM_BINS - 1 : int'(it.sample);
      if (hist_bank[it.stream_id][bin] != '1) hist_bank[it.stream_id][bin]++;
      return;
    end
    total = '0;
    for (int b = 0; b < NUM_BINS; b++) total += hist_bank[it.stream_id][b];
    if (total == 0) return;
    npos = (pos_count_q > MAX_POS) ? MAX_POS : int'(pos_count_q);
    k = 0;
    cum = '0;
    for (int b = 0; b < NUM_BINS && k < npos; b++) begin
      cum += hist_bank[it.stream_id][b];
      pct = (cum * PCT_SCALE) / total;
      while (k < npos && pct >= pos_at(k)) begin
        pv = pos_at(k);
        r.stream_id_out = it.stream_id;
        r.percentile    = pv[PCT_W-1:0];
        r.bin_value     = b[BIN_OUT_W-1:0];
        r.last          = 1'b0;
        new_pcts.push_back(r);
        k++;
      end
    end
    if (new_pcts.size() > 0) new_pcts[new_pcts.size()-1].last = 1'b1;
    for (int b = 0; b < NUM_BINS; b++) hist_bank[it.stream_id][b] = '0;
  endtask

  task automatic send_item(input in_item_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic issue(input in_item_t it, input int exp_n, input logic [9:0] exp_bin);
    out_item_t  r;
    logic [7:0] pv;
    send_item(it);
    apply_item(it);
    if (exp_n < 0) begin
      foreach (new_pcts[i]) due_pcts.push_back(new_pcts[i]);
    end else begin
      for (int i = 0; i < exp_n; i++) begin
        pv = pos_at(i);
        r.stream_id_out = it.stream_id;
        r.percentile    = pv[PCT_W-1:0];
        r.bin_value     = exp_bin;
        r.last          = (i == exp_n - 1);
        due_pcts.push_back(r);
      end
    end
  endtask

  // block idle: nothing pending, and any clear or walk tail has run out
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_pcts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_POS_COUNT: pos_count_q = val[POS_CNT_W-1:0];
      REG_POS_LOW:   pos_lo_q = val;
      REG_POS_HIGH:  pos_hi_q = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void op_row(mode_e m, int sid, int smp, int n = -1, int bin = 0);
    step_t s;
    s.is_cfg          = 1'b0;
    s.idx             = REG_POS_COUNT;
    s.data            = '0;
    s.item.mode       = m;
    s.item.stream_id  = sid[SID_W-1:0];
    s.item.sample     = smp[SAMPLE_W-1:0];
    s.exp_n           = n;
    s.exp_bin         = bin[9:0];
    steps.push_back(s);
  endfunction

  function automatic void cfg_row(cfg_reg_e idx, logic [63:0] val);
    step_t s;
    s.is_cfg  = 1'b1;
    s.idx     = idx;
    s.data    = val;
    s.item    = '0;
    s.exp_n   = -1;
    s.exp_bin = '0;
    steps.push_back(s);
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'(NUM_BINS - 1);
      2:       return 16'($urandom);
      3:       return 16'($urandom_range(NUM_BINS, 65535));
      default: return 16'($urandom_range(0, NUM_BINS - 1));
    endcase
  endfunction

  // mostly add bursts on one stream closed by a report, some loose items
  task automatic run_phase(input int n_items);
    int       left;
    int       sid;
    int       burst;
    in_item_t it;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 99) < 15) begin
        it.mode      = $urandom_range(0, 1) ? MODE_REPORT : MODE_ADD;
        it.stream_id = 4'($urandom);
        it.sample    = rand_sample();
        issue(it, -1, '0);
        left--;
      end else begin
        sid   = $urandom_range(0, NUM_STREAMS - 1);
        burst = $urandom_range(1, 8);
        it.mode      = MODE_ADD;
        it.stream_id = sid[SID_W-1:0];
        for (int j = 0; j < burst; j++) begin
          it.sample = rand_sample();
          issue(it, -1, '0);
        end
        it.mode   = MODE_REPORT;
        it.sample = 16'($urandom);
        issue(it, -1, '0);
        left -= burst + 1;
      end
    end
  endtask

  initial begin
    logic [127:0] pos_all;
    int           p;
    bit           cfg_prev;

    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    fails        = 0;
    snd_idle_pct = 13;
    rcv_idle_pct = 84;
    pos_count_q  = POS_COUNT_RST;
    pos_lo_q     = POS_LOW_RST;
    pos_hi_q     = POS_HIGH_RST;

    // reset positions are 10, 20, ... 100
    op_row(MODE_REPORT, 0, 0, 0);          // empty histogram
    op_row(MODE_ADD, 0, 0);
    op_row(MODE_REPORT, 0, 0, 10, 0);
    op_row(MODE_REPORT, 0, 0, 0);          // cleared by the report before
    op_row(MODE_ADD, 15, 16'hFFFF);
    op_row(MODE_REPORT, 15, 0, 10, NUM_BINS - 1);
    op_row(MODE_ADD, 7, NUM_BINS - 1);
    op_row(MODE_ADD, 7, NUM_BINS);         // clamps to the top bin
    op_row(MODE_ADD, 7, 512);
    op_row(MODE_REPORT, 7, 16'hFFFF);
    op_row(MODE_ADD, 2, 5);
    op_row(MODE_ADD, 2, 100);
    op_row(MODE_ADD, 2, 900);
    op_row(MODE_REPORT, 2, 0);
    // count above the maximum, list starting at zero and ending at 100
    cfg_row(REG_POS_COUNT, 64'd31);
    cfg_row(REG_POS_LOW, 64'h3C32_2819_0F0A_0500);
    cfg_row(REG_POS_HIGH, 64'h6463_605A_504B_4641);
    op_row(MODE_ADD, 9, 0);
    op_row(MODE_ADD, 9, 511);
    op_row(MODE_ADD, 9, 1000);
    op_row(MODE_REPORT, 9, 0);
    // no positions: report only clears
    cfg_row(REG_POS_COUNT, 64'd0);
    op_row(MODE_ADD, 1, 10);
    op_row(MODE_REPORT, 1, 0, 0);
    // unreachable second position cuts the list short
    cfg_row(REG_POS_COUNT, 64'd3);
    cfg_row(REG_POS_LOW, 64'h0000_0000_0032_FF0A);
    op_row(MODE_ADD, 4, 300);
    op_row(MODE_REPORT, 4, 0, 1, 300);
    // descending list: later positions land on the same bin
    cfg_row(REG_POS_COUNT, 64'd4);
    cfg_row(REG_POS_LOW, 64'h0000_0000_000A_3264);
    op_row(MODE_ADD, 6, 2);
    op_row(MODE_ADD, 6, 8);
    op_row(MODE_REPORT, 6, 0);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_prev = 1'b0;
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        if (!cfg_prev) settle_block();
        cfg_write(steps[i].idx, steps[i].data);
      end else begin
        issue(steps[i].item, steps[i].exp_n, steps[i].exp_bin);
      end
      cfg_prev = steps[i].is_cfg;
    end

    // ascending positions, all sixteen in use
    settle_block();
    p = 0;
    for (int k = 0; k < MAX_POS; k++) begin
      p += $urandom_range(0, 13);
      if (p > 100) p = 100;
      pos_all[8*k +: 8] = p[7:0];
    end
    cfg_write(REG_POS_COUNT, 64'd16);
    cfg_write(REG_POS_LOW, pos_all[63:0]);
    cfg_write(REG_POS_HIGH, pos_all[127:64]);
    run_phase(35);

    // unordered and partly unreachable positions, any count
    settle_block();
    snd_idle_pct = 84;
    rcv_idle_pct = 13;
    for (int k = 0; k < MAX_POS; k++) begin
      pos_all[8*k +: 8] = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 100))
                                                     : 8'($urandom_range(0, 255));
    end
    cfg_write(REG_POS_COUNT, 64'($urandom_range(0, 31)));
    cfg_write(REG_POS_LOW, pos_all[63:0]);
    cfg_write(REG_POS_HIGH, pos_all[127:64]);
    run_phase(35);

    // single position at 100: the top occupied bin
    settle_block();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    pos_all = {$urandom, $urandom, $urandom, $urandom};
    pos_all[7:0] = 8'd100;
    cfg_write(REG_POS_COUNT, 64'd1);
    cfg_write(REG_POS_LOW, pos_all[63:0]);
    cfg_write(REG_POS_HIGH, pos_all[127:64]);
    run_phase(30);

    settle_block();
    fails += due_pcts.size();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/shqe_pkg.sv
rtl/shqe_cfg.sv
rtl/sample_histogram_quantile_engine.sv
dv/tb.sv
